>>> src/lzss_ring_decoder_core_assert.svh
// Assertion macros for the LZSS ring decoder.
// Each takes a label, the clock, the reset, an antecedent, a consequent and a message.
`ifndef LZSS_RING_DECODER_CORE_ASSERT_SVH
`define LZSS_RING_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LZSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LZSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lzsd_pkg.sv
package lzsd_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error causes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ERR_TRUNCATED = 3'd2;
  localparam logic [2:0] ERR_OVER_CAP  = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;
  localparam logic [2:0] ERR_MISMATCH  = 3'd5;

  // Parse phases: four magic bytes, four length bytes, token body, second match byte.
  localparam logic [3:0] PH_MAGIC0 = 4'd0;
  localparam logic [3:0] PH_MAGIC3 = 4'd3;
  localparam logic [3:0] PH_LEN0   = 4'd4;
  localparam logic [3:0] PH_LEN3   = 4'd7;
  localparam logic [3:0] PH_BODY   = 4'd8;
  localparam logic [3:0] PH_SECOND = 4'd9;

  localparam logic [7:0] MAGIC [4] = '{8'h46, 8'h4C, 8'h41, 8'h32};

  localparam logic [7:0] FLAG_MSB   = 8'h80;
  localparam logic [3:0] FLAG_EMPTY = 4'd8;
  localparam logic [4:0] LEN_BIAS   = 5'd2;

  typedef struct packed {
    logic       restart;
    logic       count_byte;
    logic       take_len;
    logic [1:0] len_lane;
    logic       take_token;
    logic       take_lit;
    logic       start_copy;
    logic       rd_issue;
    logic       emit_lit;
    logic       emit_copy;
    logic       emit_final;
    logic       out_last;
    logic [1:0] final_kind;
    logic [2:0] final_cause;
  } lzsd_cmd_t;

  typedef struct packed {
    logic out_free;
    logic rd_pend;
    logic copy_many;
    logic over_cap;
    logic produced_eq_decl;
    logic match_too_long;
  } lzsd_sts_t;

endpackage

>>> src/lzsd_in_if.sv
interface lzsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

>>> src/lzsd_out_if.sv
interface lzsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic        last_of_run;
  logic [2:0]  error_cause;
  logic [31:0] written_count;
  logic [31:0] consumed_count;

  modport source (
    output valid, output kind, output data_byte, output last_of_run,
    output error_cause, output written_count, output consumed_count, input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input last_of_run,
    input error_cause, input written_count, input consumed_count, output ready
  );
endinterface

>>> src/lzsd_ram.sv
module lzsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> src/lzsd_ctrl.sv
module lzsd_ctrl
  import lzsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  input  lzsd_sts_t  sts,
  output lzsd_cmd_t  cmd
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LIT   = 4'b0010,
    S_COPY  = 4'b0100,
    S_FINAL = 4'b1000
  } state_t;

  state_t     state, state_next;
  logic [3:0] parse_phase, parse_phase_next;
  logic [7:0] flag_holder, flag_holder_next;
  logic [3:0] flag_position, flag_position_next;
  logic       halted, halted_next;
  logic       pend_final, pend_final_next;
  logic       restart_after, restart_after_next;
  logic [1:0] final_kind, final_kind_next;
  logic [2:0] final_cause, final_cause_next;
  logic       accept, st_err, st_done, go_lit, go_copy, consume, last_copy;
  logic [2:0] cause;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd                = '0;
    state_next         = state;
    parse_phase_next   = parse_phase;
    flag_holder_next   = flag_holder;
    flag_position_next = flag_position;
    halted_next        = halted;
    pend_final_next    = pend_final;
    restart_after_next = restart_after;
    final_kind_next    = final_kind;
    final_cause_next   = final_cause;
    st_err             = 1'b0;
    st_done            = 1'b0;
    go_lit             = 1'b0;
    go_copy            = 1'b0;
    consume            = 1'b0;
    last_copy          = 1'b0;
    cause              = ERR_NONE;
    accept             = in_valid && (state == S_IDLE);
    cmd.final_kind     = final_kind;
    cmd.final_cause    = final_cause;

    case (state)
      S_IDLE: begin
        if (accept && halted) begin
          cmd.restart = end_of_input;
        end else if (accept) begin
          cmd.count_byte = 1'b1;
          if (parse_phase inside {[PH_MAGIC0:PH_MAGIC3]}) begin
            if (in_byte != MAGIC[parse_phase[1:0]]) begin
              st_err = 1'b1;
              cause  = ERR_BAD_MAGIC;
            end else begin
              parse_phase_next = parse_phase + 4'd1;
            end
          end else if (parse_phase inside {[PH_LEN0:PH_LEN3]}) begin
            cmd.take_len     = 1'b1;
            cmd.len_lane     = parse_phase[1:0];
            parse_phase_next = parse_phase + 4'd1;
            if (parse_phase == PH_LEN3 && sts.over_cap) begin
              st_err = 1'b1;
              cause  = ERR_OVER_CAP;
            end
          end else if (parse_phase == PH_BODY) begin
            if (flag_position >= FLAG_EMPTY) begin
              flag_holder_next   = in_byte;
              flag_position_next = '0;
            end else if (|(flag_holder & (FLAG_MSB >> flag_position))) begin
              if (in_byte == 8'd0) begin
                if (!sts.produced_eq_decl) begin
                  st_err = 1'b1;
                  cause  = ERR_MISMATCH;
                end else begin
                  st_done = 1'b1;
                end
              end else begin
                cmd.take_token   = 1'b1;
                parse_phase_next = PH_SECOND;
              end
            end else if (sts.produced_eq_decl) begin
              st_err = 1'b1;
              cause  = ERR_OVERFLOW;
            end else begin
              go_lit             = 1'b1;
              cmd.take_lit       = 1'b1;
              flag_position_next = flag_position + 4'd1;
            end
          end else if (parse_phase == PH_SECOND) begin
            if (sts.match_too_long) begin
              st_err = 1'b1;
              cause  = ERR_OVERFLOW;
            end else begin
              go_copy            = 1'b1;
              cmd.start_copy     = 1'b1;
              parse_phase_next   = PH_BODY;
              flag_position_next = flag_position + 4'd1;
            end
          end

          // A byte that leaves the stream unfinished and ends the buffer.
          if (!st_err && !st_done && end_of_input) begin
            st_err = 1'b1;
            cause  = ERR_TRUNCATED;
          end

          pend_final_next = st_err || st_done;
          if (st_err || st_done) begin
            final_kind_next    = st_done ? KIND_DONE : KIND_ERROR;
            final_cause_next   = st_done ? ERR_NONE : cause;
            restart_after_next = end_of_input;
            halted_next        = !end_of_input;
          end

          if (go_lit) begin
            state_next = S_LIT;
          end else if (go_copy) begin
            state_next = S_COPY;
          end else if (st_err || st_done) begin
            state_next = S_FINAL;
          end
        end
      end

      S_LIT: begin
        if (sts.out_free) begin
          cmd.emit_lit = 1'b1;
          cmd.out_last = !pend_final;
          state_next   = pend_final ? S_FINAL : S_IDLE;
        end
      end

      S_COPY: begin
        consume       = sts.rd_pend && sts.out_free;
        last_copy     = consume && !sts.copy_many;
        cmd.emit_copy = consume;
        cmd.rd_issue  = !sts.rd_pend || (consume && sts.copy_many);
        cmd.out_last  = last_copy && !pend_final;
        if (last_copy) begin
          state_next = pend_final ? S_FINAL : S_IDLE;
        end
      end

      S_FINAL: begin
        if (sts.out_free) begin
          cmd.emit_final  = 1'b1;
          cmd.out_last    = 1'b1;
          cmd.restart     = restart_after;
          pend_final_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (cmd.restart) begin
      parse_phase_next   = PH_MAGIC0;
      flag_holder_next   = '0;
      flag_position_next = FLAG_EMPTY;
      halted_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      parse_phase   <= PH_MAGIC0;
      flag_holder   <= '0;
      flag_position <= FLAG_EMPTY;
      halted        <= 1'b0;
      pend_final    <= 1'b0;
      restart_after <= 1'b0;
    end else begin
      state         <= state_next;
      parse_phase   <= parse_phase_next;
      flag_holder   <= flag_holder_next;
      flag_position <= flag_position_next;
      halted        <= halted_next;
      pend_final    <= pend_final_next;
      restart_after <= restart_after_next;
    end
  end

  always_ff @(posedge clk) begin
    final_kind  <= final_kind_next;
    final_cause <= final_cause_next;
  end
endmodule

>>> src/lzsd_datapath.sv
module lzsd_datapath
  import lzsd_pkg::*;
#(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic [7:0]  in_byte,
  input  lzsd_cmd_t   cmd,
  output lzsd_sts_t   sts,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic        last_of_run,
  output logic [2:0]  error_cause,
  output logic [31:0] written_count,
  output logic [31:0] consumed_count
);
  localparam int AW = $clog2(WINDOW_DEPTH);

  logic [31:0]   output_capacity;
  logic [AW-1:0] cursor, cursor_after, raddr, match_dist;
  logic          wrapped, wrapped_after;
  logic [31:0]   produced_count, declared_length, bytes_taken;
  logic [31:0]   decl_next, remaining;
  logic [7:0]    token_high, byte_hold;
  logic [4:0]    copy_left, match_len;
  logic          rd_pend, rd_zero, byp_hit;
  logic [7:0]    byp_data, ram_q, copy_byte, wdata;
  logic          write_now, unwritten, load_out;

  assign write_now     = cmd.emit_lit || cmd.emit_copy;
  assign copy_byte     = rd_zero ? 8'd0 : (byp_hit ? byp_data : ram_q);
  assign wdata         = cmd.emit_lit ? byte_hold : copy_byte;
  assign cursor_after  = cursor + {{(AW-1){1'b0}}, write_now};
  assign wrapped_after = wrapped || (write_now && (&cursor));
  assign raddr         = cursor_after - match_dist;
  // Entries beyond the fill mark of this stream have not been written and read as zero.
  assign unwritten     = !wrapped_after && (raddr >= cursor_after);

  assign match_len = {1'b0, token_high[3:0]} + LEN_BIAS;
  assign remaining = declared_length - produced_count;
  assign decl_next = declared_length | ({24'd0, in_byte} << {cmd.len_lane, 3'b000});

  assign sts.out_free         = !out_valid || out_ready;
  assign sts.rd_pend          = rd_pend;
  assign sts.copy_many        = copy_left > 5'd1;
  // Only looked at on the last length byte, which fills the top lane.
  assign sts.over_cap         = (declared_length | {in_byte, 24'd0}) > output_capacity;
  assign sts.produced_eq_decl = produced_count == declared_length;
  assign sts.match_too_long   = {27'd0, match_len} > remaining;

  assign load_out = write_now || cmd.emit_final;

  lzsd_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (write_now),
    .waddr(cursor),
    .wdata(wdata),
    .re   (cmd.rd_issue),
    .raddr(raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      output_capacity <= '1;
      cursor          <= '0;
      wrapped         <= 1'b0;
      produced_count  <= '0;
      declared_length <= '0;
      bytes_taken     <= '0;
      copy_left       <= '0;
      rd_pend         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        output_capacity <= cfg_wdata;
      end
      if (cmd.restart) begin
        cursor          <= '0;
        wrapped         <= 1'b0;
        produced_count  <= '0;
        declared_length <= '0;
        bytes_taken     <= '0;
      end else begin
        cursor  <= cursor_after;
        wrapped <= wrapped_after;
        if (write_now) begin
          produced_count <= produced_count + 32'd1;
        end
        if (cmd.take_len) begin
          declared_length <= decl_next;
        end
        if (cmd.count_byte && !(&bytes_taken)) begin
          bytes_taken <= bytes_taken + 32'd1;
        end
      end
      if (cmd.start_copy) begin
        copy_left <= match_len;
      end else if (cmd.emit_copy) begin
        copy_left <= copy_left - 5'd1;
      end
      if (cmd.rd_issue) begin
        rd_pend <= 1'b1;
      end else if (cmd.emit_copy) begin
        rd_pend <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_token) begin
      token_high <= in_byte;
    end
    if (cmd.take_lit) begin
      byte_hold <= in_byte;
    end
    if (cmd.start_copy) begin
      match_dist <= AW'({token_high[7:4], in_byte});
    end
    if (cmd.rd_issue) begin
      rd_zero  <= unwritten;
      byp_hit  <= write_now && (raddr == cursor);
      byp_data <= wdata;
    end
    if (write_now) begin
      kind           <= KIND_BYTE;
      data_byte      <= wdata;
      last_of_run    <= cmd.out_last;
      error_cause    <= ERR_NONE;
      written_count  <= '0;
      consumed_count <= '0;
    end else if (cmd.emit_final) begin
      kind           <= cmd.final_kind;
      data_byte      <= 8'd0;
      last_of_run    <= 1'b1;
      error_cause    <= cmd.final_cause;
      written_count  <= (cmd.final_kind == KIND_DONE) ? produced_count : 32'd0;
      consumed_count <= (cmd.final_kind == KIND_DONE) ? bytes_taken : 32'd0;
    end
  end
endmodule

>>> src/lzss_ring_decoder_core.sv
// LZSS decoder with a 4096-byte history ring, fed one compressed byte per input word.
// in_ch carries a stream byte and end_of_input; out_ch carries decoded bytes and then
// one done word (written and consumed counts) or one error word per stream.
// Configuration: output_capacity is written through cfg_we and cfg_wdata; the user
// must write it only while idle, as the block does not enforce this. A header or flag
// byte is accepted and updates the parse state. A literal is accepted, then its word
// is loaded into the output register from S_LIT once the register is free. The second
// byte of a match starts a copy: one ring read is issued, then one byte a cycle leaves
// for the output register while the next read is issued and the register is free, the
// ring's single read port setting the pace. A done or error word is loaded from
// S_FINAL. Input is accepted again in the cycle after the last word is loaded.
// The output register decouples the two sides: a stalled receiver holds the word and
// the decoder waits for the register to free before it produces another.
// Reset clears all stream state and sets output_capacity to all ones. The ring itself
// is not swept: a fill mark tracks which entries this stream has written, and the
// others read as zero, so a new stream starts at once after end_of_input.
// After done or error, bytes are swallowed until one carries end_of_input.
`include "lzss_ring_decoder_core_assert.svh"

module lzss_ring_decoder_core
  import lzsd_pkg::*;
#(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  lzsd_in_if.sink     in_ch,
  lzsd_out_if.source  out_ch
);
  lzsd_cmd_t cmd;
  lzsd_sts_t sts;

  // The controller owns the parse state and the sequencing of emitted words.
  lzsd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_byte     (in_ch.in_byte),
    .end_of_input(in_ch.end_of_input),
    .sts         (sts),
    .cmd         (cmd)
  );

  // The datapath holds the ring, counters, copy engine and output register.
  lzsd_datapath #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_byte       (in_ch.in_byte),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .kind          (out_ch.kind),
    .data_byte     (out_ch.data_byte),
    .last_of_run   (out_ch.last_of_run),
    .error_cause   (out_ch.error_cause),
    .written_count (out_ch.written_count),
    .consumed_count(out_ch.consumed_count)
  );

  // A done or error word always closes the run of its input byte.
  `LZSD_ASSERT_NOW(a_final_is_last, clk, rst, out_ch.valid && (out_ch.kind != KIND_BYTE), out_ch.last_of_run, "final word without last_of_run")
  // Only error words carry a cause.
  `LZSD_ASSERT_NOW(a_cause_matches_kind, clk, rst, out_ch.valid, (out_ch.kind == KIND_ERROR) == (out_ch.error_cause != ERR_NONE), "error cause disagrees with kind")
  // No input is taken while a ring read for a match copy is outstanding.
  `LZSD_ASSERT_NOW(a_no_accept_in_copy, clk, rst, sts.rd_pend, !in_ch.ready, "input ready during match copy")
  // A restart leaves the decoder idle and ready for the first byte of the next stream.
  `LZSD_ASSERT_NEXT(a_restart_idle, clk, rst, cmd.restart, in_ch.ready && !sts.rd_pend, "decoder busy after restart")
endmodule
